// ----- src/wto_pkg.sv -----
// Shared constants, codes and types of the wavetable oscillator.
`default_nettype none

package wto_pkg;

  localparam int unsigned TableDepth    = 4096;
  localparam int unsigned AddrBits      = 12;
  localparam int unsigned LenBits       = AddrBits + 1;
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned FreqBits      = 32;
  localparam int unsigned SorBits       = 32;
  localparam int unsigned StartBits     = 16;
  localparam int unsigned PhaseFracBits = 20;
  localparam int unsigned PhaseBits     = AddrBits + PhaseFracBits;

  localparam int unsigned FreqFrac      = 14;
  localparam int unsigned SorFrac       = 24;
  localparam int unsigned StartFrac     = 16;
  localparam int unsigned IncShift      = FreqFrac + SorFrac - PhaseFracBits;
  localparam int unsigned ProdBits      = FreqBits + SorBits;
  localparam int unsigned IncFullBits   = ProdBits - IncShift;
  localparam int unsigned RestartShift  = PhaseFracBits - StartFrac;

  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 32;
  localparam int unsigned InDataBits    = 64;
  localparam int unsigned ModeBits      = 2;

  localparam logic [LenBits-1:0]   LenReset    = LenBits'(TableDepth);
  localparam logic [SorBits-1:0]   SorReset    = SorBits'(1431656);
  localparam logic                 InterpReset = 1'b1;
  localparam logic [StartBits-1:0] StartReset  = '0;

  typedef enum logic [ModeBits-1:0] {
    ModeTick    = 2'd0,
    ModeLoad    = 2'd1,
    ModeRestart = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgTableLength  = 2'd0,
    CfgSizeOverRate = 2'd1,
    CfgInterpolate  = 2'd2,
    CfgStartPhase   = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic                 tick;
    logic                 restart;
    logic                 neg;
    logic [PhaseBits-1:0] inc;
  } phase_cmd_t;

  typedef struct packed {
    logic [AddrBits-1:0]      idx;
    logic [AddrBits-1:0]      nxt;
    logic [PhaseFracBits-1:0] frac;
  } table_rd_t;

endpackage

`default_nettype wire

// ----- src/wto_table.sv -----
// Wave sample store: one write port, two registered read ports.
`default_nettype none

module wto_table (
  input  wire logic                            clk_i,
  input  wire logic                            wr_en_i,
  input  wire logic [wto_pkg::AddrBits-1:0]    wr_addr_i,
  input  wire logic [wto_pkg::SampleBits-1:0]  wr_data_i,
  input  wire logic                            rd_en_i,
  input  wire logic [wto_pkg::AddrBits-1:0]    rd_addr0_i,
  input  wire logic [wto_pkg::AddrBits-1:0]    rd_addr1_i,
  output logic      [wto_pkg::SampleBits-1:0]  rd_data0_o,
  output logic      [wto_pkg::SampleBits-1:0]  rd_data1_o
);

  logic [wto_pkg::SampleBits-1:0] mem_q [wto_pkg::TableDepth];
  logic [wto_pkg::SampleBits-1:0] rd_data0_q;
  logic [wto_pkg::SampleBits-1:0] rd_data1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_q <= mem_q[rd_addr0_i];
      rd_data1_q <= mem_q[rd_addr1_i];
    end
  end

  assign rd_data0_o = rd_data0_q;
  assign rd_data1_o = rd_data1_q;

endmodule

`default_nettype wire

// ----- src/wto_phase.sv -----
// Phase accumulator with restart, wrap and a modulo pass after a length change.
`default_nettype none

module wto_phase (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire wto_pkg::phase_cmd_t            cmd_i,
  input  wire logic [wto_pkg::LenBits-1:0]    len_i,
  input  wire logic [wto_pkg::StartBits-1:0]  start_phase_i,
  input  wire logic                           reduce_start_i,
  output wto_pkg::table_rd_t                  rd_o,
  output logic                                busy_o
);

  localparam int unsigned CycBits  = wto_pkg::PhaseBits + 1;
  localparam int unsigned RedBits  = wto_pkg::LenBits + wto_pkg::AddrBits - 1;
  localparam int unsigned StepBits = $clog2(wto_pkg::AddrBits);
  localparam int unsigned RstBits  = wto_pkg::LenBits + wto_pkg::StartBits;
  localparam logic [StepBits-1:0] LastStep = StepBits'(wto_pkg::AddrBits - 1);

  typedef enum logic [1:0] {
    PhRun    = 2'b01,
    PhReduce = 2'b10
  } ph_state_e;

  ph_state_e                       state_q, state_d;
  logic [StepBits-1:0]             step_q, step_d;
  logic [wto_pkg::PhaseBits-1:0]   phase_q, phase_d;
  logic [wto_pkg::PhaseBits-1:0]   raw_q, raw_d;

  logic [CycBits-1:0]              cycle;
  logic [CycBits-1:0]              sum, diff, wrap_up, wrap_dn;
  logic [RstBits-1:0]              rst_prod;
  logic [wto_pkg::PhaseBits-1:0]   restart_val;
  logic [wto_pkg::AddrBits-1:0]    idx;
  logic [wto_pkg::LenBits-1:0]     idx_p1;
  logic [RedBits-1:0]              red_div;
  logic                            red_fit;
  logic [wto_pkg::AddrBits-1:0]    red_idx;

  assign idx     = phase_q[wto_pkg::PhaseBits-1:wto_pkg::PhaseFracBits];
  assign idx_p1  = {1'b0, idx} + wto_pkg::LenBits'(1);
  assign cycle   = {len_i, {wto_pkg::PhaseFracBits{1'b0}}};

  // forward step wraps once past the end, backward step borrows one cycle
  assign sum     = {1'b0, phase_q} + {1'b0, cmd_i.inc};
  assign diff    = {1'b0, phase_q} - {1'b0, cmd_i.inc};
  assign wrap_up = (sum >= cycle) ? (sum - cycle) : sum;
  assign wrap_dn = diff[wto_pkg::PhaseBits] ? (diff + cycle) : diff;

  assign rst_prod    = RstBits'(len_i) * RstBits'(start_phase_i);
  assign restart_val = wto_pkg::PhaseBits'(rst_prod) << wto_pkg::RestartShift;

  // one restoring step of idx mod len per cycle
  assign red_div = RedBits'(len_i) << step_q;
  assign red_fit = RedBits'(idx) >= red_div;
  assign red_idx = idx - red_div[wto_pkg::AddrBits-1:0];

  // raw_q holds the phase as last set by a tick or restart; every pass folds
  // from it, so back-to-back length writes fold against the final length only
  always_comb begin
    phase_d = phase_q;
    raw_d   = raw_q;
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      PhRun: begin
        if (reduce_start_i) begin
          state_d = PhReduce;
          step_d  = LastStep;
          phase_d = raw_q;
        end else if (cmd_i.restart) begin
          phase_d = restart_val;
          raw_d   = restart_val;
        end else if (cmd_i.tick) begin
          phase_d = cmd_i.neg ? wrap_dn[wto_pkg::PhaseBits-1:0]
                              : wrap_up[wto_pkg::PhaseBits-1:0];
          raw_d   = phase_d;
        end
      end
      PhReduce: begin
        if (reduce_start_i) begin
          phase_d = raw_q;
          step_d  = LastStep;
        end else begin
          if (red_fit) begin
            phase_d = {red_idx, phase_q[wto_pkg::PhaseFracBits-1:0]};
          end
          if (step_q == '0) begin
            state_d = PhRun;
          end else begin
            step_d = step_q - StepBits'(1);
          end
        end
      end
      default: begin
        state_d = PhRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PhRun;
      step_q  <= '0;
      phase_q <= '0;
      raw_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      raw_q   <= raw_d;
    end
  end

  assign rd_o.idx  = idx;
  assign rd_o.nxt  = (idx_p1 >= len_i) ? '0 : idx_p1[wto_pkg::AddrBits-1:0];
  assign rd_o.frac = phase_q[wto_pkg::PhaseFracBits-1:0];
  assign busy_o    = (state_q == PhReduce);

endmodule

`default_nettype wire

// ----- src/wto_interp.sv -----
// Linear interpolation between two neighboring wave samples.
`default_nettype none

module wto_interp (
  input  wire logic signed [wto_pkg::SampleBits-1:0]    base_i,
  input  wire logic signed [wto_pkg::SampleBits-1:0]    next_i,
  input  wire logic        [wto_pkg::PhaseFracBits-1:0] frac_i,
  input  wire logic                                     interp_en_i,
  output logic signed      [wto_pkg::SampleBits-1:0]    sample_o
);

  localparam int unsigned ProdBits = wto_pkg::PhaseFracBits + wto_pkg::SampleBits + 2;

  logic signed [wto_pkg::SampleBits:0] slope;
  logic signed [ProdBits-1:0]          prod;
  logic        [wto_pkg::SampleBits-1:0] step;

  assign slope = {next_i[wto_pkg::SampleBits-1], next_i}
               - {base_i[wto_pkg::SampleBits-1], base_i};
  assign prod  = $signed({1'b0, frac_i}) * slope;
  // arithmetic shift floors toward minus infinity; keep the sample bits
  assign step  = prod[wto_pkg::PhaseFracBits +: wto_pkg::SampleBits];

  assign sample_o = interp_en_i ? (base_i + $signed(step)) : base_i;

endmodule

`default_nettype wire

// ----- src/wavetable_oscillator_unit.sv -----
// Top level of the wavetable oscillator: stream ports, pipeline and config registers.
//
// Usage:
//   Input words arrive on s_axis; tuser carries the kind of word (tick, table load,
//   phase restart). A tick yields one output word on m_axis holding the next sample;
//   loads and restarts yield none. Configuration registers are written through
//   cfg_we_i / cfg_index_i / cfg_wdata_i while the stream is quiet.
// Throughput and pipeline:
//   One word per cycle unless the output stalls or a modulo pass runs. A tick passes
//   through the input register, product register, increment register with phase
//   update and table read, and interpolation into the output register.
//   The phase register feeds its own update, so back-to-back ticks run at full rate.
// Table length writes:
//   Writing table_length starts a modulo pass that folds the stored phase into the
//   new cycle; s_axis_tready stays low during that pass.
// Reset:
//   Clears the pipeline, sets phase to zero and the registers to their defaults.
//   Table contents are undefined until loaded.
// Stalls:
//   When m_axis_tready is low the output word holds; earlier stages keep filling
//   until each holds a word, and only then s_axis_tready drops.
`default_nettype none

module wavetable_oscillator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // freq [31:0], table_address [43:32], table_value [59:44], zero [63:60]
  input  wire logic [wto_pkg::InDataBits-1:0]    s_axis_tdata,
  // mode [1:0]
  input  wire logic [wto_pkg::ModeBits-1:0]      s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // sample [15:0]
  output logic signed [wto_pkg::SampleBits-1:0]  m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [wto_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [wto_pkg::CfgDataBits-1:0]   cfg_wdata_i
);

  localparam int unsigned AddrLo  = wto_pkg::FreqBits;
  localparam int unsigned ValueLo = AddrLo + wto_pkg::AddrBits;

  // configuration registers
  logic [wto_pkg::LenBits-1:0]    len_q;
  logic [wto_pkg::SorBits-1:0]    sor_q;
  logic                           interp_q;
  logic [wto_pkg::StartBits-1:0]  start_q;
  logic [wto_pkg::LenBits-1:0]    cfg_len, len_clamped;
  logic                           reduce_start;

  // input stage
  logic                           w_v_q;
  logic [wto_pkg::ModeBits-1:0]   w_mode_q;
  logic [wto_pkg::FreqBits-1:0]   w_fmag_q;
  logic                           w_neg_q;
  logic [wto_pkg::AddrBits-1:0]   w_addr_q;
  logic [wto_pkg::SampleBits-1:0] w_value_q;
  logic [wto_pkg::FreqBits-1:0]   in_freq;

  // product stage
  logic                           p_v_q;
  logic [wto_pkg::ModeBits-1:0]   p_mode_q;
  logic [wto_pkg::ProdBits-1:0]   p_prod_q, prod_c;
  logic                           p_neg_q;
  logic [wto_pkg::AddrBits-1:0]   p_addr_q;
  logic [wto_pkg::SampleBits-1:0] p_value_q;

  // increment stage (phase update, table access)
  logic                           x_v_q;
  logic [wto_pkg::ModeBits-1:0]   x_mode_q;
  logic [wto_pkg::PhaseBits-1:0]  x_inc_q, inc_c;
  logic                           x_neg_q;
  logic [wto_pkg::AddrBits-1:0]   x_addr_q;
  logic [wto_pkg::SampleBits-1:0] x_value_q;
  logic [wto_pkg::IncFullBits-1:0] inc_full;
  logic [wto_pkg::PhaseBits:0]    cyc_m1;

  // interpolation stage and output register
  logic                                  y_v_q;
  logic [wto_pkg::PhaseFracBits-1:0]     y_frac_q;
  logic [wto_pkg::SampleBits-1:0]        y_base, y_next;
  logic signed [wto_pkg::SampleBits-1:0] sample_c;
  logic                                  out_v_q;
  logic signed [wto_pkg::SampleBits-1:0] out_sample_q;

  // flow control
  logic s_accept, z_free, y_free, x_fire, x_free, p_free, w_free;
  logic x_tick, x_load, x_restart, busy;

  wto_pkg::phase_cmd_t phase_cmd;
  wto_pkg::table_rd_t  table_rd;

  //--------------------------------------------------------------------------
  // Configuration: clamp table_length into 1..depth, kick the modulo pass
  //--------------------------------------------------------------------------
  assign cfg_len     = cfg_wdata_i[wto_pkg::LenBits-1:0];
  assign len_clamped = (cfg_len == '0) ? wto_pkg::LenBits'(1)
                     : (cfg_len > wto_pkg::LenBits'(wto_pkg::TableDepth))
                       ? wto_pkg::LenBits'(wto_pkg::TableDepth) : cfg_len;
  assign reduce_start = cfg_we_i && (cfg_index_i == wto_pkg::CfgTableLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= wto_pkg::LenReset;
      sor_q    <= wto_pkg::SorReset;
      interp_q <= wto_pkg::InterpReset;
      start_q  <= wto_pkg::StartReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wto_pkg::CfgTableLength:  len_q    <= len_clamped;
        wto_pkg::CfgSizeOverRate: sor_q    <= cfg_wdata_i[wto_pkg::SorBits-1:0];
        wto_pkg::CfgInterpolate:  interp_q <= cfg_wdata_i[0];
        wto_pkg::CfgStartPhase:   start_q  <= cfg_wdata_i[wto_pkg::StartBits-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Flow control: each stage advances when the one after it has room.
  // Only ticks travel past the increment stage.
  //--------------------------------------------------------------------------
  assign x_tick    = (x_mode_q == wto_pkg::ModeTick);
  assign x_load    = (x_mode_q == wto_pkg::ModeLoad);
  assign x_restart = (x_mode_q == wto_pkg::ModeRestart);

  assign z_free = !out_v_q || m_axis_tready;
  assign y_free = !y_v_q || z_free;
  assign x_fire = x_v_q && !busy && (!x_tick || y_free);
  assign x_free = !x_v_q || x_fire;
  assign p_free = !p_v_q || x_free;
  assign w_free = !w_v_q || p_free;

  assign s_axis_tready = w_free && !busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
      x_v_q   <= 1'b0;
      y_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (w_free) w_v_q   <= s_accept;
      if (p_free) p_v_q   <= w_v_q;
      if (x_free) x_v_q   <= p_v_q;
      if (y_free) y_v_q   <= x_fire && x_tick;
      if (z_free) out_v_q <= y_v_q;
    end
  end

  //--------------------------------------------------------------------------
  // Input register: take the frequency magnitude right away
  //--------------------------------------------------------------------------
  assign in_freq = s_axis_tdata[wto_pkg::FreqBits-1:0];

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      w_mode_q  <= s_axis_tuser;
      w_neg_q   <= in_freq[wto_pkg::FreqBits-1];
      w_fmag_q  <= in_freq[wto_pkg::FreqBits-1]
                 ? (~in_freq + wto_pkg::FreqBits'(1)) : in_freq;
      w_addr_q  <= s_axis_tdata[AddrLo +: wto_pkg::AddrBits];
      w_value_q <= s_axis_tdata[ValueLo +: wto_pkg::SampleBits];
    end
  end

  //--------------------------------------------------------------------------
  // Product register: |freq| * size_over_rate
  //--------------------------------------------------------------------------
  assign prod_c = wto_pkg::ProdBits'(w_fmag_q) * wto_pkg::ProdBits'(sor_q);

  always_ff @(posedge clk_i) begin
    if (p_free && w_v_q) begin
      p_mode_q  <= w_mode_q;
      p_neg_q   <= w_neg_q;
      p_prod_q  <= prod_c;
      p_addr_q  <= w_addr_q;
      p_value_q <= w_value_q;
    end
  end

  //--------------------------------------------------------------------------
  // Increment register: truncate to phase fraction bits, clip below one cycle
  //--------------------------------------------------------------------------
  assign inc_full = p_prod_q[wto_pkg::ProdBits-1:wto_pkg::IncShift];
  assign cyc_m1   = {len_q, {wto_pkg::PhaseFracBits{1'b0}}} - (wto_pkg::PhaseBits + 1)'(1);
  assign inc_c    = (inc_full > wto_pkg::IncFullBits'(cyc_m1))
                  ? cyc_m1[wto_pkg::PhaseBits-1:0] : inc_full[wto_pkg::PhaseBits-1:0];

  always_ff @(posedge clk_i) begin
    if (x_free && p_v_q) begin
      x_mode_q  <= p_mode_q;
      x_neg_q   <= p_neg_q;
      x_inc_q   <= inc_c;
      x_addr_q  <= p_addr_q;
      x_value_q <= p_value_q;
    end
  end

  assign phase_cmd.tick    = x_fire && x_tick;
  assign phase_cmd.restart = x_fire && x_restart;
  assign phase_cmd.neg     = x_neg_q;
  assign phase_cmd.inc     = x_inc_q;

  wto_phase u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (phase_cmd),
    .len_i          (len_q),
    .start_phase_i  (start_q),
    .reduce_start_i (reduce_start),
    .rd_o           (table_rd),
    .busy_o         (busy)
  );

  // read both neighbors at the current phase as the tick leaves this stage
  wto_table u_table (
    .clk_i      (clk_i),
    .wr_en_i    (x_fire && x_load),
    .wr_addr_i  (x_addr_q),
    .wr_data_i  (x_value_q),
    .rd_en_i    (x_fire && x_tick),
    .rd_addr0_i (table_rd.idx),
    .rd_addr1_i (table_rd.nxt),
    .rd_data0_o (y_base),
    .rd_data1_o (y_next)
  );

  always_ff @(posedge clk_i) begin
    if (x_fire && x_tick) begin
      y_frac_q <= table_rd.frac;
    end
  end

  //--------------------------------------------------------------------------
  // Interpolate and hold the word until the receiver takes it
  //--------------------------------------------------------------------------
  wto_interp u_interp (
    .base_i      ($signed(y_base)),
    .next_i      ($signed(y_next)),
    .frac_i      (y_frac_q),
    .interp_en_i (interp_q),
    .sample_o    (sample_c)
  );

  always_ff @(posedge clk_i) begin
    if (z_free && y_v_q) begin
      out_sample_q <= sample_c;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_sample_q;

endmodule

`default_nettype wire

// ----- src/wto_checker.sv -----
// Port-level checks of the wavetable oscillator, bound to the top level.
`default_nettype none

module wto_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [wto_pkg::SampleBits-1:0]    m_axis_tdata,
  input wire logic                              cfg_we_i,
  input wire logic [wto_pkg::CfgIdxBits-1:0]    cfg_index_i
);

  // no output word while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // a table length write blocks input from the next cycle on
  a_len_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == wto_pkg::CfgTableLength |=> !s_axis_tready)
    else $error("input taken right after table length write");

  // the modulo pass still blocks input on its last step
  a_len_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == wto_pkg::CfgTableLength |-> ##12 !s_axis_tready)
    else $error("modulo pass ended early");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

endmodule

bind wavetable_oscillator_unit wto_checker u_checker (.*);

`default_nettype wire

// ----- verif/wavetable_oscillator_unit_tb.sv -----
// Self-checking testbench for the wavetable oscillator: directed words, then random phases.
`timescale 1ns / 1ps

module wavetable_oscillator_unit_tb;

  // Run shape
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned NumPhases    = 14;
  localparam int unsigned WordsPerPhase = 90;   // 14 x 90 random words
  localparam int unsigned CalmPhase    = 5;     // no idling on either side here
  localparam int unsigned IdlePercent  = 26;
  localparam int unsigned SettleCycles = 8;     // the pipe plus slack
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned MaxReports   = 40;

  // Mode 3 is not a defined kind; the block must drop such words silently.
  localparam logic [wto_pkg::ModeBits-1:0] ModeSpare = 2'd3;

  localparam wto_pkg::cfg_index_e RegOrder [4] = '{wto_pkg::CfgTableLength,
                                                   wto_pkg::CfgSizeOverRate,
                                                   wto_pkg::CfgInterpolate,
                                                   wto_pkg::CfgStartPhase};

  localparam logic [31:0] FreqCorners [4] = '{32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h0000_0000, 32'hFFFF_FFFF};

  // One row of the directed table. 'known' marks a row whose sample is typed in.
  typedef struct packed {
    logic [wto_pkg::ModeBits-1:0]   mode;
    logic [31:0]                    freq;
    logic [wto_pkg::AddrBits-1:0]   addr;
    logic [wto_pkg::SampleBits-1:0] value;
    logic                           known;
    logic [wto_pkg::SampleBits-1:0] sample;
  } dir_row_t;

  // Directed run with table_length 4 and the other registers at reset values.
  localparam int unsigned DirCount = 19;
  localparam dir_row_t DirRows [DirCount] = '{
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd0,    16'h7FFF, 1'b0, 16'h0000},
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd1,    16'h8000, 1'b0, 16'h0000},
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd2,    16'h0000, 1'b0, 16'h0000},
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd3,    16'hFFFF, 1'b0, 16'h0000},
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd4095, 16'h5555, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'h0000_0000, 12'd0,    16'h0000, 1'b1, 16'h7FFF},
    '{wto_pkg::ModeTick,    32'h7FFF_FFFF, 12'd0,    16'h0000, 1'b1, 16'h7FFF},
    '{wto_pkg::ModeTick,    32'h8000_0000, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{ModeSpare,            32'hFFFF_FFFF, 12'hFFF,  16'hFFFF, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'h0000_0001, 12'd0,    16'h0000, 1'b1, 16'h7FFF},
    '{wto_pkg::ModeRestart, 32'h0000_0000, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'hFFFF_FFFF, 12'd0,    16'h0000, 1'b1, 16'h7FFF},
    '{wto_pkg::ModeTick,    32'h0040_0000, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd1,    16'h7FFF, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'h0FFF_FFFF, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'hC000_0000, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{wto_pkg::ModeLoad,    32'h0000_0000, 12'd2,    16'h8000, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'h0000_0000, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{wto_pkg::ModeTick,    32'h0012_3456, 12'd0,    16'h0000, 1'b0, 16'h0000}
  };

  // Block inputs; reset falls at time zero
  logic                            clk_i         = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid = 1'b0;
  logic [wto_pkg::InDataBits-1:0]  s_axis_tdata  = '0;
  logic [wto_pkg::ModeBits-1:0]    s_axis_tuser  = wto_pkg::ModeTick;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [wto_pkg::CfgIdxBits-1:0]  cfg_index_i   = wto_pkg::CfgTableLength;
  logic [wto_pkg::CfgDataBits-1:0] cfg_wdata_i   = '0;

  // Block outputs
  logic                                  s_axis_tready;
  logic                                  m_axis_tvalid;
  logic signed [wto_pkg::SampleBits-1:0] m_axis_tdata;

  // Oscillator mirror: registers, phase accumulator and wave table
  logic [wto_pkg::LenBits-1:0]    len_reg    = wto_pkg::LenReset;
  logic [wto_pkg::SorBits-1:0]    sor_reg    = wto_pkg::SorReset;
  logic                           interp_reg = wto_pkg::InterpReset;
  logic [wto_pkg::StartBits-1:0]  start_reg  = wto_pkg::StartReset;
  logic [63:0]                    phase_acc  = '0;
  logic signed [wto_pkg::SampleBits-1:0] wave_mem [wto_pkg::TableDepth];
  bit                             wave_written [wto_pkg::TableDepth];

  logic [wto_pkg::SampleBits-1:0] expected_samples [$];
  int unsigned                    mismatch_count = 0;
  int unsigned                    cycle_count    = 0;
  bit                             calm           = 1'b0;

  wavetable_oscillator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Entries per cycle as the block sees them: zero acts as one, above depth clamps.
  function automatic logic [63:0] active_len();
    if (len_reg == '0) return 64'd1;
    if (len_reg > wto_pkg::LenBits'(wto_pkg::TableDepth)) return 64'(wto_pkg::TableDepth);
    return 64'(len_reg);
  endfunction

  // Apply one input word to the mirror. Returns 1 and the sample for a tick.
  function automatic bit oscillate(input logic [wto_pkg::ModeBits-1:0] mode,
                                   input logic [wto_pkg::InDataBits-1:0] data,
                                   output logic [wto_pkg::SampleBits-1:0] sample);
    logic [63:0] span, idx, nxt, frac, fmag, inc;
    longint      base, slope, val;
    sample = '0;
    span   = active_len() << wto_pkg::PhaseFracBits;
    if (mode == wto_pkg::ModeLoad) begin
      wave_mem[data[43:32]]     = data[59:44];
      wave_written[data[43:32]] = 1'b1;
      return 1'b0;
    end
    if (mode == wto_pkg::ModeRestart) begin
      phase_acc = (active_len() * 64'(start_reg)) << wto_pkg::RestartShift;
      return 1'b0;
    end
    if (mode != wto_pkg::ModeTick) return 1'b0;

    // Fold a phase left past the end by a shorter table
    if (phase_acc >= span) phase_acc = phase_acc % span;
    idx  = phase_acc >> wto_pkg::PhaseFracBits;
    frac = phase_acc & ((64'd1 << wto_pkg::PhaseFracBits) - 64'd1);
    nxt  = (idx + 64'd1 >= active_len()) ? 64'd0 : idx + 64'd1;
    base = wave_mem[idx[wto_pkg::AddrBits-1:0]];
    val  = base;
    if (interp_reg) begin
      // Arithmetic shift floors the fraction-times-slope term
      slope = longint'(wave_mem[nxt[wto_pkg::AddrBits-1:0]]) - base;
      val   = base + ((longint'(frac) * slope) >>> wto_pkg::PhaseFracBits);
    end
    sample = val[wto_pkg::SampleBits-1:0];

    // Increment from |freq| x size_over_rate, truncated then held below one cycle
    fmag = {32'd0, data[31:0]};
    if (data[31]) fmag = (64'd1 << 32) - fmag;
    inc = (fmag * {32'd0, sor_reg}) >> wto_pkg::IncShift;
    if (inc > span - 64'd1) inc = span - 64'd1;
    if (!data[31]) begin
      phase_acc = phase_acc + inc;
      if (phase_acc >= span) phase_acc = phase_acc - span;
    end else if (phase_acc < inc) begin
      phase_acc = phase_acc + (span - inc);
    end else begin
      phase_acc = phase_acc - inc;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] random_freq();
    case ($urandom_range(0, 9))
      0: return FreqCorners[$urandom_range(0, 3)];
      1, 2: return $urandom();
      // mostly audio-range rates, both signs
      default: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Present one word, record what it should produce, hold until the handshake.
  task automatic send_word(input logic [wto_pkg::ModeBits-1:0] mode,
                           input logic [31:0] freq,
                           input logic [wto_pkg::AddrBits-1:0] addr,
                           input logic [wto_pkg::SampleBits-1:0] value,
                           input logic known,
                           input logic [wto_pkg::SampleBits-1:0] known_sample);
    logic [wto_pkg::SampleBits-1:0] predicted;
    logic [wto_pkg::InDataBits-1:0] data;
    if (!calm) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    data = {4'b0, value, addr, freq};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= mode;
    if (oscillate(mode, data, predicted))
      expected_samples.push_back(known ? known_sample : predicted);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, wait out every pending sample, then let loads and restarts clear the pipe.
  task automatic drain_outputs(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write the selected registers on back-to-back edges; keep the write enable high between.
  task automatic program_regs(input logic [3:0] sel,
                              input logic [wto_pkg::LenBits-1:0] len,
                              input logic [wto_pkg::SorBits-1:0] sor,
                              input logic interp,
                              input logic [wto_pkg::StartBits-1:0] start);
    for (int j = 0; j < 4; j++) begin
      if (sel[j]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= RegOrder[j];
        case (RegOrder[j])
          wto_pkg::CfgTableLength: begin
            cfg_wdata_i <= wto_pkg::CfgDataBits'(len);
            len_reg = len;
          end
          wto_pkg::CfgSizeOverRate: begin
            cfg_wdata_i <= sor;
            sor_reg = sor;
          end
          wto_pkg::CfgInterpolate: begin
            cfg_wdata_i <= wto_pkg::CfgDataBits'(interp);
            interp_reg = interp;
          end
          default: begin
            cfg_wdata_i <= wto_pkg::CfgDataBits'(start);
            start_reg = start;
          end
        endcase
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // Load the two entries the next tick will read if either was never written.
  task automatic load_tick_entries();
    logic [63:0] span, cur, idx, nxt;
    span = active_len() << wto_pkg::PhaseFracBits;
    cur  = (phase_acc >= span) ? (phase_acc % span) : phase_acc;
    idx  = cur >> wto_pkg::PhaseFracBits;
    nxt  = (idx + 64'd1 >= active_len()) ? 64'd0 : idx + 64'd1;
    if (!wave_written[idx[wto_pkg::AddrBits-1:0]])
      send_word(wto_pkg::ModeLoad, '0, idx[wto_pkg::AddrBits-1:0],
                wto_pkg::SampleBits'($urandom()), 1'b0, '0);
    if (!wave_written[nxt[wto_pkg::AddrBits-1:0]])
      send_word(wto_pkg::ModeLoad, '0, nxt[wto_pkg::AddrBits-1:0],
                wto_pkg::SampleBits'($urandom()), 1'b0, '0);
  endtask

  initial begin : stimulus
    logic [wto_pkg::LenBits-1:0]   len;
    logic [wto_pkg::SorBits-1:0]   sor;
    logic [wto_pkg::StartBits-1:0] start;
    int unsigned                   pick;

    rst_ni <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: shrink the cycle to four entries, keep the reset rate and interpolation.
    program_regs(4'b0001, 13'd4, '0, 1'b0, '0);
    for (int i = 0; i < DirCount; i++)
      send_word(DirRows[i].mode, DirRows[i].freq, DirRows[i].addr, DirRows[i].value,
                DirRows[i].known, DirRows[i].sample);

    // Random phases, each with fresh register settings written while the block is quiet.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_outputs(SettleCycles);
      case (ph)
        0: len = 13'd1;
        1: len = 13'd0;
        2: len = 13'd4096;
        3: len = 13'd2;
        6: len = 13'd8191;
        8: len = 13'd5000;
        10: len = 13'd4095;
        default: len = wto_pkg::LenBits'($urandom_range(3, 48));
      endcase
      case (ph % 5)
        1: sor = 32'hFFFF_FFFF;
        2: sor = 32'h0000_0000;
        3: sor = $urandom();
        default: sor = $urandom_range(0, 32'h0200_0000);
      endcase
      case (ph)
        4: start = 16'hFFFF;
        7: start = 16'h0000;
        default: start = wto_pkg::StartBits'($urandom());
      endcase
      calm = (ph == CalmPhase);
      program_regs(4'b1111, len, sor, ph[0], start);

      for (int n = 0; n < WordsPerPhase; n++) begin
        // Now and then hold off until every sample is out
        if ($urandom_range(0, 199) == 0) drain_outputs(1);
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          load_tick_entries();
          send_word(wto_pkg::ModeTick, random_freq(), wto_pkg::AddrBits'($urandom()),
                    wto_pkg::SampleBits'($urandom()), 1'b0, '0);
        end else if (pick < 80)
          send_word(wto_pkg::ModeLoad, $urandom(),
                    wto_pkg::AddrBits'($urandom_range(0, wto_pkg::TableDepth - 1)),
                    wto_pkg::SampleBits'($urandom()), 1'b0, '0);
        else if (pick < 90)
          send_word(wto_pkg::ModeRestart, $urandom(), wto_pkg::AddrBits'($urandom()),
                    wto_pkg::SampleBits'($urandom()), 1'b0, '0);
        else
          send_word(ModeSpare, $urandom(), wto_pkg::AddrBits'($urandom()),
                    wto_pkg::SampleBits'($urandom()), 1'b0, '0);
      end
    end

    calm = 1'b0;
    drain_outputs(2 * SettleCycles);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Sink: check each accepted output word against the oldest pending sample, stall at random.
  always @(posedge clk_i) begin : sink
    logic [wto_pkg::SampleBits-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("output word %h with no tick pending", m_axis_tdata));
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("sample %h, want %h", m_axis_tdata, want));
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
